// ----- rtl/core/sm3_pkg.sv -----
// sm3 hash core: shared constants, types and round functions
package sm3_pkg;

  localparam int WordW       = 32;
  localparam int BlockWords  = 16;
  localparam int DigestWords = 8;
  localparam int Rounds      = 64;
  localparam int SwitchRound = 15;
  localparam int RoundW      = $clog2(Rounds);
  localparam int CountW      = $clog2(BlockWords);
  localparam int DigCntW     = $clog2(DigestWords);

  localparam logic [WordW-1:0] T_LOW  = 32'h79cc4519;
  localparam logic [WordW-1:0] T_HIGH = 32'h7a879d8a;

  typedef logic [WordW-1:0] word_t;

  localparam word_t IV [DigestWords] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // controller to datapath commands
  typedef struct packed {
    logic              load_word;   // shift an input beat into the window
    logic              load_iv;     // reload chaining value with the iv
    logic              init_rounds; // copy chaining value, or the iv on a start beat, into a..h
    logic              round_en;    // run one compression round
    logic [RoundW-1:0] round_idx;   // current round number
    logic              finish;      // fold a..h into the chaining value
    logic              capture;     // latch digest for output
  } sm3_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;                 // digest beats still pending
  } sm3_status_t;

  // left rotate by a 5-bit amount, zero is the identity
  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [2*WordW-1:0] d;
    d = {x, x} << n;
    return d[2*WordW-1:WordW];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ----- rtl/core/sm3_ctrl.sv -----
// sm3 hash core: block sequencing state machine
module sm3_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_start,
  input  logic                 in_final,
  output logic                 in_ready,
  input  sm3_pkg::sm3_status_t status,
  output sm3_pkg::sm3_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_ROUND,
    S_FINISH
  } state_t;

  state_t                      state;
  logic [sm3_pkg::CountW-1:0]  word_count;
  logic [sm3_pkg::RoundW-1:0]  round_cnt;
  logic                        final_flag;
  logic                        accept;
  logic                        go;

  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;
  // a final block waits here until the previous digest has drained
  assign go       = (state == S_FINISH) && (!final_flag || !status.out_busy);

  // command decode
  always_comb begin
    cmd             = '0;
    cmd.load_word   = accept;
    cmd.load_iv     = accept && in_start;
    cmd.init_rounds = accept && (word_count == sm3_pkg::CountW'(sm3_pkg::BlockWords - 1));
    cmd.round_en    = (state == S_ROUND);
    cmd.round_idx   = round_cnt;
    cmd.finish      = go;
    cmd.capture     = go && final_flag;
  end

  // state, word and round counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      word_count <= '0;
      round_cnt  <= '0;
      final_flag <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            word_count <= word_count + 1'b1;
            if (cmd.init_rounds) begin
              final_flag <= in_final;
              round_cnt  <= '0;
              state      <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          round_cnt <= round_cnt + 1'b1;
          if (round_cnt == sm3_pkg::RoundW'(sm3_pkg::Rounds - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (go) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/sm3_datapath.sv -----
// sm3 hash core: message window, round registers, chaining value, digest output
module sm3_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sm3_pkg::sm3_cmd_t    cmd,
  output sm3_pkg::sm3_status_t status,
  input  sm3_pkg::word_t       in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sm3_pkg::word_t       out_word,
  output logic                 out_last
);

  sm3_pkg::word_t              win   [sm3_pkg::BlockWords];
  sm3_pkg::word_t              regs  [sm3_pkg::DigestWords];
  sm3_pkg::word_t              chain [sm3_pkg::DigestWords];
  sm3_pkg::word_t              dig   [sm3_pkg::DigestWords];
  logic [sm3_pkg::DigCntW-1:0] out_cnt;

  sm3_pkg::word_t w_new, w_prime, t_rot, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic           high_round;

  // next expanded word, window holds W[j] .. W[j+15]
  assign w_new = sm3_pkg::perm1(win[0] ^ win[7] ^ sm3_pkg::rotl(win[13], 5'd15))
               ^ sm3_pkg::rotl(win[3], 5'd7) ^ win[10];
  assign w_prime = win[0] ^ win[4];

  // one compression round
  always_comb begin
    high_round = (cmd.round_idx > sm3_pkg::RoundW'(sm3_pkg::SwitchRound));
    t_rot = sm3_pkg::rotl(high_round ? sm3_pkg::T_HIGH : sm3_pkg::T_LOW,
                          cmd.round_idx[4:0]);
    a12 = sm3_pkg::rotl(regs[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + regs[4] + t_rot, 5'd7);
    ss2 = ss1 ^ a12;
    if (high_round) begin
      ff = (regs[0] & regs[1]) | (regs[1] & regs[2]) | (regs[0] & regs[2]);
      gg = (regs[4] & regs[5]) | (~regs[4] & regs[6]);
    end else begin
      ff = regs[0] ^ regs[1] ^ regs[2];
      gg = regs[4] ^ regs[5] ^ regs[6];
    end
    tt1 = ff + regs[3] + ss2 + w_prime;
    tt2 = gg + regs[7] + ss1 + win[0];
  end

  // message window: input beats and expansion share one shift
  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.round_en) begin
      for (int i = 0; i < sm3_pkg::BlockWords - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[sm3_pkg::BlockWords-1] <= cmd.load_word ? in_word : w_new;
    end
  end

  // working registers a..h
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sm3_pkg::DigestWords; i++) begin
        regs[i] <= '0;
      end
    end else if (cmd.init_rounds) begin
      for (int i = 0; i < sm3_pkg::DigestWords; i++) begin
        regs[i] <= cmd.load_iv ? sm3_pkg::IV[i] : chain[i];
      end
    end else if (cmd.round_en) begin
      regs[0] <= tt1;
      regs[1] <= regs[0];
      regs[2] <= sm3_pkg::rotl(regs[1], 5'd9);
      regs[3] <= regs[2];
      regs[4] <= sm3_pkg::perm0(tt2);
      regs[5] <= regs[4];
      regs[6] <= sm3_pkg::rotl(regs[5], 5'd19);
      regs[7] <= regs[6];
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sm3_pkg::DigestWords; i++) begin
        chain[i] <= sm3_pkg::IV[i];
      end
    end else if (cmd.load_iv) begin
      for (int i = 0; i < sm3_pkg::DigestWords; i++) begin
        chain[i] <= sm3_pkg::IV[i];
      end
    end else if (cmd.finish) begin
      for (int i = 0; i < sm3_pkg::DigestWords; i++) begin
        chain[i] <= chain[i] ^ regs[i];
      end
    end
  end

  // digest shift-out buffer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < sm3_pkg::DigestWords; i++) begin
        dig[i] <= chain[i] ^ regs[i];
      end
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < sm3_pkg::DigestWords - 1; i++) begin
        dig[i] <= dig[i+1];
      end
    end
  end

  // digest beat control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_cnt   <= '0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
      out_cnt   <= '0;
    end else if (out_valid && out_ready) begin
      out_cnt <= out_cnt + 1'b1;
      if (out_last) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_word        = dig[0];
  assign out_last        = (out_cnt == sm3_pkg::DigCntW'(sm3_pkg::DigestWords - 1));
  assign status.out_busy = out_valid;

endmodule

// ----- rtl/core/sm3_block_hash.sv -----
// sm3 hash core: top level joining controller and datapath
//
// Input stream s_*: one beat per 32-bit big-endian word of already padded
// message data, sixteen beats to a block. s_tuser[0] (start_message) on a
// beat reloads the chaining value with the standard iv before that word is
// taken; s_tuser[1] (final_block) on the sixteenth beat marks the message's
// last block. After the sixteenth beat s_tready stays low through the
// compression rounds, one round at a time in the single shared round unit,
// and then through the fold of the result into the chaining value.
// Output stream m_*: after a final block, eight digest beats, word A first,
// m_tlast on word H. The first digest beat is valid in the cycle after the fold.
// The digest sits in its own buffer, so the next message's words are taken
// while the receiver stalls; only a further final block waits in its fold
// cycle until the last digest beat has gone.
// Reset (rst, synchronous) empties the block, loads the iv, clears a..h and
// drops m_tvalid.
module sm3_block_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] msg_word
  input  logic [1:0]  s_tuser,   // [0] start_message, [1] final_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast    // digest_last
);

  sm3_pkg::sm3_cmd_t    cmd;
  sm3_pkg::sm3_status_t status;

  sm3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_start (s_tuser[0]),
    .in_final (s_tuser[1]),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sm3_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_word   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata),
    .out_last  (m_tlast)
  );

  // no input beat is taken while the round unit is busy
  a_no_load_in_rounds: assert property (@(posedge clk) disable iff (rst)
    cmd.round_en |-> !s_tready)
    else $error("input accepted during compression rounds");

  // a new digest never overwrites one still being sent
  a_capture_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !m_tvalid)
    else $error("digest captured while output busy");

  // the last digest beat ends the output run
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("output still valid after last digest beat");

  // rounds start at round zero right after the sixteenth word
  a_rounds_start: assert property (@(posedge clk) disable iff (rst)
    cmd.init_rounds |=> (cmd.round_en && cmd.round_idx == '0))
    else $error("compression did not start at round zero");

endmodule

// ----- bench/tb_sm3_block_hash.sv -----
// testbench for the sm3 block hash core: streamed messages checked against a local sm3 model
module tb_sm3_block_hash;
  typedef sm3_pkg::word_t word_t;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 100;

  typedef struct packed {
    word_t word;
    logic  last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;     // [31:0] msg_word
  logic [1:0]  s_tuser = '0;     // [0] start_message, [1] final_block
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [31:0] digest_word
  logic        m_tlast;          // digest_last

  // model state of the hash
  word_t       hash_chain [8];
  word_t       block_buf [16];
  logic [3:0]  fill_count;
  digest_beat_t expected_digest [$];

  int error_count = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  sm3_block_hash dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // long receiver hold-off, counted down per cycle
  always @(posedge clk) begin
    if (hold_left > 0) hold_left = hold_left - 1;
  end

  function automatic word_t iv_word(input int idx);
    case (idx)
      0: return 32'h7380166F;
      1: return 32'h4914B2B9;
      2: return 32'h172442D7;
      3: return 32'hDA8A0600;
      4: return 32'hA96F30BC;
      5: return 32'h163138AA;
      6: return 32'hE38DEE4D;
      default: return 32'hB0FB0E4E;
    endcase
  endfunction

  // rotate left, zero amount leaves the word as is
  function automatic word_t rot_left(input word_t x, input int unsigned n);
    int unsigned k;
    k = n % 32;
    if (k == 0) return x;
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic word_t mix_p0(input word_t x);
    return x ^ rot_left(x, 9) ^ rot_left(x, 17);
  endfunction

  function automatic word_t mix_p1(input word_t x);
    return x ^ rot_left(x, 15) ^ rot_left(x, 23);
  endfunction

  // expand the buffered block, run 64 rounds, fold into the chain
  task automatic compress_block_model();
    word_t w [68];
    word_t wx [64];
    word_t a, b, c, d, e, f, g, h;
    word_t tconst, a12, ss1, ss2, tt1, tt2, ffv, ggv;
    int i;
    for (i = 0; i < 16; i++) w[i] = block_buf[i];
    for (i = 16; i < 68; i++)
      w[i] = mix_p1(w[i-16] ^ w[i-9] ^ rot_left(w[i-3], 15)) ^ rot_left(w[i-13], 7) ^ w[i-6];
    for (i = 0; i < 64; i++) wx[i] = w[i] ^ w[i+4];
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (i = 0; i < 64; i++) begin
      // constant and boolean functions switch after round fifteen
      if (i > 15) begin
        tconst = 32'h7a879d8a;
        ffv = (a & b) | (b & c) | (a & c);
        ggv = (e & f) | (~e & g);
      end else begin
        tconst = 32'h79cc4519;
        ffv = a ^ b ^ c;
        ggv = e ^ f ^ g;
      end
      a12 = rot_left(a, 12);
      ss1 = rot_left(a12 + e + rot_left(tconst, i), 7);
      ss2 = ss1 ^ a12;
      tt1 = ffv + d + ss2 + wx[i];
      tt2 = ggv + h + ss1 + w[i];
      d = c;
      c = rot_left(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rot_left(f, 19);
      f = e;
      e = mix_p0(tt2);
    end
    hash_chain[0] ^= a; hash_chain[1] ^= b; hash_chain[2] ^= c; hash_chain[3] ^= d;
    hash_chain[4] ^= e; hash_chain[5] ^= f; hash_chain[6] ^= g; hash_chain[7] ^= h;
  endtask

  // update model for one accepted word, queue digest beats on a final block
  task automatic predict_digest(input word_t word, input bit start_msg, input bit final_blk);
    int i;
    if (start_msg)
      for (i = 0; i < 8; i++) hash_chain[i] = iv_word(i);
    block_buf[fill_count] = word;
    fill_count = fill_count + 4'd1;
    if (fill_count == 4'd0) begin
      compress_block_model();
      if (final_blk)
        for (i = 0; i < 8; i++) expected_digest.push_back('{hash_chain[i], i == 7});
    end
  endtask

  // offer one message word and wait for its beat
  task automatic send_word(input word_t word, input bit start_msg, input bit final_blk);
    bit rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= {final_blk, start_msg};
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk);
      rdy = (s_tready === 1'b1);
      @(posedge clk);
    end
    predict_digest(word, start_msg, final_blk);
    words_sent = words_sent + 1;
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return 32'h00000000;
      1: return 32'hFFFFFFFF;
      default: return $urandom();
    endcase
  endfunction

  // one message of whole blocks, with a little noise on the flags
  task automatic send_message(input int n_blocks);
    bit drop_start;
    bit st, fb;
    int b, i;
    drop_start = ($urandom_range(9) == 0);
    for (b = 0; b < n_blocks; b++) begin
      for (i = 0; i < 16; i++) begin
        st = (b == 0 && i == 0 && !drop_start) || ($urandom_range(39) == 0);
        fb = (i == 15) ? (b == n_blocks - 1) : bit'($urandom_range(1));
        send_word(pick_word(), st, fb);
      end
    end
  endtask

  task automatic lower_valid();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_digest_drained();
    while (expected_digest.size() != 0) @(posedge clk);
  endtask

  // receiver: ready pattern and digest beat check
  initial begin
    bit hs;
    word_t got_word;
    logic got_last;
    digest_beat_t want;
    forever begin
      @(negedge clk);
      hs = (m_tvalid === 1'b1) && (m_tready === 1'b1) && (rst === 1'b0);
      got_word = m_tdata;
      got_last = m_tlast;
      @(posedge clk);
      if (hs) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest beat, expected none, actual %h last %b",
                   $time, got_word, got_last);
          error_count = error_count + 1;
        end else begin
          want = expected_digest.pop_front();
          if (got_word !== want.word) begin
            $display("%0t: digest word mismatch, expected %h, actual %h",
                     $time, want.word, got_word);
            error_count = error_count + 1;
          end
          if (got_last !== want.last) begin
            $display("%0t: digest last mismatch, expected %b, actual %b",
                     $time, want.last, got_last);
            error_count = error_count + 1;
          end
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // "abc" padded to one block, a known sm3 vector
  task automatic test_abc_vector();
    int i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_word(32'h61626380, 1'b1, 1'b0);
    for (i = 1; i < 15; i++) send_word(32'h00000000, 1'b0, 1'b0);
    send_word(32'h00000018, 1'b0, 1'b1);
  endtask

  // extreme words, restart in mid-block, final flag on a partial word,
  // restart on the sixteenth word
  task automatic test_edge_words();
    int i;
    word_t w;
    for (i = 0; i < 16; i++) begin
      case (i % 4)
        0: w = 32'hFFFFFFFF;
        1: w = 32'h00000000;
        2: w = 32'h80000000;
        default: w = 32'h00000001;
      endcase
      send_word(w, i == 0 || i == 9 || i == 15, i == 4 || i == 15);
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_words);
    int goal;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    goal = words_sent + n_words;
    while (words_sent < goal) send_message($urandom_range(1, 3));
  endtask

  // receiver stalls long so digests pile up and the input backs up
  task automatic test_receiver_holdoff();
    lower_valid();
    wait_digest_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 400;
    send_message(1);
    send_message(1);
    send_message(1);
    lower_valid();
    wait_digest_drained();
  endtask

  // sender waits for every digest beat before the next message
  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    send_message(2);
    lower_valid();
    wait_digest_drained();
    send_message(1);
  endtask

  initial begin
    int i;
    fill_count = 4'd0;
    for (i = 0; i < 8; i++) hash_chain[i] = iv_word(i);
    for (i = 0; i < 16; i++) block_buf[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_abc_vector();
    test_edge_words();
    test_random_traffic(0, 0, 16);
    test_random_traffic(47, 0, 16);
    test_random_traffic(0, 47, 16);
    test_random_traffic(10, 10, 16);
    test_receiver_holdoff();
    test_drain_pause();

    // wind down
    lower_valid();
    wait_digest_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sm3_pkg.sv
rtl/core/sm3_ctrl.sv
rtl/core/sm3_datapath.sv
rtl/core/sm3_block_hash.sv
bench/tb_sm3_block_hash.sv
